### rtl/mcfr_pkg.sv
// -----------------------------------------------------------------------------
// mcfr_pkg
// Shared types, codes and arithmetic helpers for the motor CAN feedback
// receiver.
// -----------------------------------------------------------------------------
`default_nettype none

package mcfr_pkg;

   // sizing
   localparam int MOTORS_DEFAULT = 4;
   localparam int CFG_ENTRIES    = 4;   // motor entry registers in the csr map
   localparam int CSR_INDEX_W    = 3;
   localparam int CSR_DATA_W     = 59;
   localparam int COUNT_W        = 3;
   localparam int ID_W           = 11;
   localparam int LIMIT_W        = 16;
   localparam int FCOUNT_W       = 32;
   localparam int MASK_W         = 32;
   localparam int ACK_W          = 64;
   localparam int DATA_W         = 64;
   localparam int SCALED_W       = 24;
   localparam int PROD_W         = 32;
   localparam int FOLD_W         = 38;
   localparam int POS_BITS       = 16;
   localparam int VT_BITS        = 12;

   // motor entry layout
   localparam int ENT_POS_LSB = 11;
   localparam int ENT_VEL_LSB = 27;
   localparam int ENT_TOR_LSB = 43;

   // csr indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_MOTOR_COUNT  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MOTOR_ENTRY0 = 3'd1;

   // protocol constants
   localparam logic [7:0]      OP_READ         = 8'h33;
   localparam logic [7:0]      OP_WRITE        = 8'h55;
   localparam logic [ID_W-1:0] BROADCAST_ID    = 11'h7FF;
   localparam logic [ID_W:0]   FEEDBACK_OFFSET = 12'h010;
   localparam logic [3:0]      NIBBLE          = 4'hF;
   localparam logic [15:0]     ID_SPAN         = 16'd32;

   // command codes
   localparam logic [1:0] CMD_FRAME     = 2'd0;
   localparam logic [1:0] CMD_CLR_ACK   = 2'd1;
   localparam logic [1:0] CMD_CLR_SEEN  = 2'd2;

   typedef enum logic [1:0] {
      RK_IGNORED  = 2'd0,
      RK_FEEDBACK = 2'd1,
      RK_ACK      = 2'd2,
      RK_CLEAR    = 2'd3
   } result_kind_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MUL,
      S_FOLD,
      S_FIN
   } seq_state_type;

   typedef struct packed {
      logic [1:0]        command;
      logic [ID_W-1:0]   std_id;
      logic              is_standard;
      logic [3:0]        length;
      logic [DATA_W-1:0] frame_data;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]                 result_kind;
      logic [1:0]                 motor_index;
      logic [3:0]                 error_flags;
      logic [3:0]                 motor_low_id;
      logic signed [SCALED_W-1:0] position;
      logic signed [SCALED_W-1:0] velocity;
      logic signed [SCALED_W-1:0] torque;
      logic [7:0]                 driver_temperature;
      logic [7:0]                 rotor_temperature;
      logic [FCOUNT_W-1:0]        frame_count;
      logic [MASK_W-1:0]          seen_mask;
      logic [ACK_W-1:0]           ack_record;
   } rsp_payload_type;

   // Division by 2^b - 1: n = q * (2^b - 1) + r is kept through every fold.
   typedef struct packed {
      logic [FOLD_W-1:0] q;
      logic [FOLD_W-1:0] r;
   } fold_type;

   // numerator x * 2L * 32 = (x * L) << 6
   function automatic fold_type fold_start(logic [PROD_W-1:0] prod);
      fold_type f;
      f.q = '0;
      f.r = {prod, 6'b0};
      return f;
   endfunction

   function automatic fold_type fold_step(fold_type f, int unsigned bits);
      logic [FOLD_W-1:0] mask;
      logic [FOLD_W-1:0] hi;
      fold_type          o;
      mask = (FOLD_W'(1) << bits) - FOLD_W'(1);
      hi   = f.r >> bits;
      o.q  = f.q + hi;
      o.r  = (f.r & mask) + hi;
      return o;
   endfunction

   // last fold, remainder correction, then remove the 32 * L offset
   function automatic logic [SCALED_W-1:0] fold_finish(fold_type f, int unsigned bits,
                                                       logic [LIMIT_W-1:0] lim);
      fold_type              g;
      logic [FOLD_W-1:0]     m;
      logic [SCALED_W-1:0]   q;
      g = fold_step(f, bits);
      m = (FOLD_W'(1) << bits) - FOLD_W'(1);
      q = g.q[SCALED_W-1:0] + SCALED_W'(g.r >= m);
      return q - SCALED_W'({lim, 5'b0});
   endfunction

endpackage

`default_nettype wire

### rtl/mcfr_if.sv
// -----------------------------------------------------------------------------
// mcfr_if
// Valid/ready word channels for received frames and for results.
// -----------------------------------------------------------------------------
`default_nettype none

interface mcfr_req_if;
   import mcfr_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface mcfr_rsp_if;
   import mcfr_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/motor_can_feedback_receiver_core.sv
// -----------------------------------------------------------------------------
// motor_can_feedback_receiver_core
// Receive side of a CAN motor bus: register acknowledgement capture, motor
// lookup, feedback unpack and fixed-point scaling, seen-id mask, frame counts.
// -----------------------------------------------------------------------------
// One word in, exactly one result word out. A feedback frame that matches a
// motor entry goes from acceptance to its result in the output register
// through accept + lookup + count-memory read, multiply + count write-back, two
// divide folds, then last fold + offset; every other word (acknowledgement,
// clears, ignored frames) goes from acceptance straight to the output register.
// The three scaling lanes run side by side through the multiply-and-fold
// divider by 2^b - 1. req ready is high only between items; the output
// register lets a new word in while the last result still waits on rsp.
// Per-motor frame counts live in a small synchronous memory with one valid
// bit per entry, so no clearing pass is needed after reset.
// Configuration (motor count, motor entries) is to be written by the user through
// csr_* only while the block is idle; the block itself does not enforce this.
`default_nettype none

module motor_can_feedback_receiver_core #(
   parameter int MOTORS = mcfr_pkg::MOTORS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [mcfr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [mcfr_pkg::CSR_DATA_W-1:0]    csr_wdata,
   mcfr_req_if.sink                           req_chan,
   mcfr_rsp_if.source                         rsp_chan
);
   import mcfr_pkg::*;

   localparam int IDX_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;

   // ---------------------------------------------------------------- state
   seq_state_type             state_ff, state_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_payload_type           rsp_data_ff, rsp_data_in;

   logic [COUNT_W-1:0]        motor_count_ff;
   logic [CSR_DATA_W-1:0]     entry_ff [MOTORS];

   logic [MASK_W-1:0]         seen_ff, seen_in;
   logic                      ack_held_ff, ack_held_in;
   logic [ACK_W-1:0]          ack_rec_ff, ack_rec_in;

   // frame count memory, one valid bit per entry
   logic [FCOUNT_W-1:0]       count_mem [MOTORS];
   logic [MOTORS-1:0]         count_vld_ff;
   logic [FCOUNT_W-1:0]       rd_count_ff;
   logic                      rd_vld_ff;
   logic [FCOUNT_W-1:0]       count_ff, count_in;

   // per-item working registers
   result_kind_type           kind_ff, kind_in;
   logic [IDX_W-1:0]          idx_ff;
   logic [DATA_W-1:0]         data_ff;
   logic [LIMIT_W-1:0]        plim_ff, vlim_ff, tlim_ff;
   logic [PROD_W-1:0]         pprod_ff, vprod_ff, tprod_ff;
   fold_type                  pfold_ff, vfold_ff, tfold_ff;

   // ---------------------------------------------------------------- decode
   req_payload_type           rq;
   logic                      accept;
   logic                      req_ready;
   logic                      load;
   logic [15:0]               aid;
   logic [7:0]                opc;
   logic [3:0]                low;
   logic                      frame_ok;
   logic                      ack_match;
   logic                      fb_frame;
   logic [COUNT_W-1:0]        active;
   logic                      found;
   logic [IDX_W-1:0]          lk_idx;
   logic [CSR_DATA_W-1:0]     lk_entry;

   assign rq     = req_chan.payload;
   assign accept = req_chan.valid && req_ready;
   assign aid    = rq.frame_data[15:0];
   assign opc    = rq.frame_data[23:16];
   assign low    = rq.frame_data[3:0] & NIBBLE;

   // length codes 8..15 all count as full frames
   assign frame_ok  = (rq.command == CMD_FRAME) && rq.is_standard && rq.length[3];
   assign ack_match = frame_ok && ((opc == OP_READ) || (opc == OP_WRITE)) &&
                      (aid != 16'd0) && (aid <= ID_SPAN) && !ack_held_ff;
   assign fb_frame  = frame_ok && !ack_match && (rq.std_id != BROADCAST_ID);
   assign active    = (motor_count_ff > COUNT_W'(MOTORS)) ? COUNT_W'(MOTORS)
                                                           : motor_count_ff;

   // Lookup: id or id + 0x10 first, low nibble second; lowest entry wins.
   always_comb begin
      logic              hit_id;
      logic              hit_low;
      logic [IDX_W-1:0]  idx_id;
      logic [IDX_W-1:0]  idx_low;
      logic [ID_W-1:0]   cid;
      hit_id  = 1'b0;
      hit_low = 1'b0;
      idx_id  = '0;
      idx_low = '0;
      for (int i = MOTORS - 1; i >= 0; i--) begin
         cid = entry_ff[i][ID_W-1:0];
         if (COUNT_W'(i) < active) begin
            if ((cid == rq.std_id) ||
                (({1'b0, cid} + FEEDBACK_OFFSET) == {1'b0, rq.std_id})) begin
               hit_id = 1'b1;
               idx_id = IDX_W'(i);
            end
            if ((cid[3:0] & NIBBLE) == low) begin
               hit_low = 1'b1;
               idx_low = IDX_W'(i);
            end
         end
      end
      found    = hit_id || hit_low;
      lk_idx   = hit_id ? idx_id : idx_low;
      lk_entry = entry_ff[lk_idx];
   end

   always_comb begin
      case (rq.command)
         CMD_CLR_ACK, CMD_CLR_SEEN: kind_in = RK_CLEAR;
         CMD_FRAME: begin
            if (ack_match)
               kind_in = RK_ACK;
            else if (fb_frame && found)
               kind_in = RK_FEEDBACK;
            else
               kind_in = RK_IGNORED;
         end
         default: kind_in = RK_IGNORED;
      endcase
   end

   // seen mask and held acknowledgement change at the accepting edge
   always_comb begin
      seen_in     = seen_ff;
      ack_held_in = ack_held_ff;
      ack_rec_in  = ack_rec_ff;
      if (accept) begin
         case (rq.command)
            CMD_CLR_ACK: begin
               ack_held_in = 1'b0;
               ack_rec_in  = '0;
            end
            CMD_CLR_SEEN: seen_in = '0;
            CMD_FRAME: begin
               if (ack_match) begin
                  // id 32 is acknowledged but has no mask bit
                  if (aid < ID_SPAN)
                     seen_in = seen_ff | (MASK_W'(1) << aid[4:0]);
                  ack_held_in = 1'b1;
                  ack_rec_in  = {aid, opc, rq.frame_data[31:24], rq.frame_data[63:32]};
               end else if (fb_frame) begin
                  if (rq.std_id < ID_W'(MASK_W))
                     seen_in = seen_in | (MASK_W'(1) << rq.std_id[4:0]);
                  seen_in = seen_in | (MASK_W'(1) << low);
               end
            end
            default: seen_in = seen_ff;
         endcase
      end
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept)
               state_in = (kind_in == RK_FEEDBACK) ? S_MUL : S_FIN;
         end
         S_MUL:  state_in = S_FOLD;
         S_FOLD: state_in = S_FIN;
         S_FIN: begin
            if (load)
               state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == S_IDLE);
      load      = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_chan.ready);
   end

   assign req_chan.ready = req_ready;
   assign rsp_valid_in   = load || (rsp_valid_ff && !rsp_chan.ready);

   // read-modify-write of the matched motor's count; the write lands in S_MUL,
   // well before the next item can read
   assign count_in = (rd_vld_ff ? rd_count_ff : '0) + FCOUNT_W'(1);

   // result word
   always_comb begin
      logic [2:0] idx_ext;
      idx_ext     = 3'(idx_ff);
      rsp_data_in = '0;
      rsp_data_in.result_kind = kind_ff;
      rsp_data_in.seen_mask   = seen_ff;
      rsp_data_in.ack_record  = ack_rec_ff;
      if (kind_ff == RK_FEEDBACK) begin
         rsp_data_in.motor_index        = idx_ext[1:0];
         rsp_data_in.error_flags        = data_ff[7:4];
         rsp_data_in.motor_low_id       = data_ff[3:0];
         rsp_data_in.position           = $signed(fold_finish(pfold_ff, POS_BITS, plim_ff));
         rsp_data_in.velocity           = $signed(fold_finish(vfold_ff, VT_BITS, vlim_ff));
         rsp_data_in.torque             = $signed(fold_finish(tfold_ff, VT_BITS, tlim_ff));
         rsp_data_in.driver_temperature = data_ff[55:48];
         rsp_data_in.rotor_temperature  = data_ff[63:56];
         rsp_data_in.frame_count        = count_ff;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   // ---------------------------------------------------------------- control regs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         motor_count_ff <= '0;
         seen_ff        <= '0;
         ack_held_ff    <= 1'b0;
         ack_rec_ff     <= '0;
         count_vld_ff   <= '0;
         for (int i = 0; i < MOTORS; i++)
            entry_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         seen_ff      <= seen_in;
         ack_held_ff  <= ack_held_in;
         ack_rec_ff   <= ack_rec_in;
         if (state_ff == S_MUL)
            count_vld_ff[idx_ff] <= 1'b1;
         if (csr_we) begin
            if (csr_index == CSR_MOTOR_COUNT)
               motor_count_ff <= csr_wdata[COUNT_W-1:0];
            // only the first CFG_ENTRIES entries are reachable from the map
            for (int i = 0; i < MOTORS; i++) begin
               if ((i < CFG_ENTRIES) && (csr_index == CSR_INDEX_W'(i) + CSR_MOTOR_ENTRY0))
                  entry_ff[i] <= csr_wdata;
            end
         end
      end
   end

   // ---------------------------------------------------------------- count memory
   always_ff @(posedge clock) begin
      if (accept)
         rd_count_ff <= count_mem[lk_idx];
      if (state_ff == S_MUL)
         count_mem[idx_ff] <= count_in;
   end

   // ---------------------------------------------------------------- datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff   <= kind_in;
         idx_ff    <= lk_idx;
         data_ff   <= rq.frame_data;
         rd_vld_ff <= count_vld_ff[lk_idx];
         plim_ff   <= lk_entry[ENT_POS_LSB +: LIMIT_W];
         vlim_ff   <= lk_entry[ENT_VEL_LSB +: LIMIT_W];
         tlim_ff   <= lk_entry[ENT_TOR_LSB +: LIMIT_W];
      end
      if (state_ff == S_MUL) begin
         count_ff <= count_in;
         // raw position {b1,b2}, velocity {b3,b4 hi}, torque {b4 lo,b5}
         pprod_ff <= PROD_W'({data_ff[15:8], data_ff[23:16]}) * PROD_W'(plim_ff);
         vprod_ff <= PROD_W'({data_ff[31:24], data_ff[39:36]}) * PROD_W'(vlim_ff);
         tprod_ff <= PROD_W'({data_ff[35:32], data_ff[47:40]}) * PROD_W'(tlim_ff);
      end
      if (state_ff == S_FOLD) begin
         pfold_ff <= fold_step(fold_step(fold_start(pprod_ff), POS_BITS), POS_BITS);
         vfold_ff <= fold_step(fold_step(fold_start(vprod_ff), VT_BITS), VT_BITS);
         tfold_ff <= fold_step(fold_step(fold_start(tprod_ff), VT_BITS), VT_BITS);
      end
      if (load)
         rsp_data_ff <= rsp_data_in;
   end

   // ---------------------------------------------------------------- assertions
   // held flag and record move together (a held id is never zero)
   a_ack_consistent: assert property (@(posedge clock) disable iff (reset)
      ack_held_ff == (ack_rec_ff != '0))
      else $error("ack flag and ack record disagree");

   // a count write-back only follows a freshly accepted feedback word
   a_single_rmw: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL) |-> ($past(accept) && (kind_ff == RK_FEEDBACK)))
      else $error("count memory written outside a feedback item");

   // a finished result waits while the output register is still occupied
   a_fin_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && rsp_valid_ff && !rsp_chan.ready) |=> (state_ff == S_FIN))
      else $error("result left before output register was free");

endmodule

`default_nettype wire

### verif/motor_can_feedback_receiver_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// motor_can_feedback_receiver_core_tb
// Self-checking bench for the CAN feedback receiver. Frame and clear words go
// in with random gaps. A local predictor works out every result word, and
// each word that comes back is compared with it field by field. The run steps
// through several motor tables, output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module motor_can_feedback_receiver_core_tb;
   import mcfr_pkg::*;

   localparam int HALF_PERIOD      = 6;
   localparam int RESET_CYCLES     = 9;
   localparam int N_MOTORS         = 4;
   localparam int RANDOM_PER_PHASE = 320;
   localparam int BURST_WORDS      = 24;
   localparam int HOLD_OFF_CYCLES  = 200;
   localparam int DRAIN_CYCLES     = 6;     // worst-case latency plus margin
   localparam int MAX_REPORTS      = 10;

   // command 3 has no meaning; the block must ignore it
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   mcfr_req_if req_bus ();
   mcfr_rsp_if rsp_bus ();

   motor_can_feedback_receiver_core #(
      .MOTORS (N_MOTORS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus)
   );

   // ------------------------------------------------------------------------
   // Predictor state: mirrors the block's registers and its internal state
   // ------------------------------------------------------------------------
   logic [COUNT_W-1:0]    tbl_count;
   logic [CSR_DATA_W-1:0] tbl_entry [N_MOTORS];
   logic [MASK_W-1:0]     seen_ids;
   logic                  ack_valid;
   logic [ACK_W-1:0]      ack_word;
   logic [FCOUNT_W-1:0]   fb_counts [N_MOTORS];

   rsp_payload_type       frame_outcomes [$];   // one per accepted word, in order
   int unsigned           error_count;
   bit                    gaps_on;              // random idling on both sides
   int unsigned           rsp_hold_cycles;      // long receiver hold-off request

   always #HALF_PERIOD clock = ~clock;

   // mostly short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (!gaps_on)
         return 0;
      r = $urandom_range(99, 0);
      if (r < 55)
         return 0;
      if (r < 88)
         return $urandom_range(3, 1);
      if (r < 97)
         return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------
   // motor_count above the table size acts as a full table
   function automatic int unsigned active_motors();
      return (tbl_count > N_MOTORS) ? N_MOTORS : int'(tbl_count);
   endfunction

   // exact id or id + 0x10 first, then the low nibble; -1 when nothing hits
   function automatic int find_motor(logic [ID_W-1:0] id, logic [3:0] low);
      int unsigned   n;
      logic [ID_W:0] can_id;
      n = active_motors();
      for (int i = 0; i < n; i++) begin
         can_id = {1'b0, tbl_entry[i][ID_W-1:0]};
         if (can_id == {1'b0, id} || can_id + FEEDBACK_OFFSET == {1'b0, id})
            return i;
      end
      for (int i = 0; i < n; i++) begin
         if (tbl_entry[i][3:0] == low)
            return i;
      end
      return -1;
   endfunction

   // floor(raw * 2L * 32 / (2^bits - 1)) - 32L, kept to 24 bits
   function automatic logic [SCALED_W-1:0] scale_raw(logic [15:0] raw,
                                                     logic [LIMIT_W-1:0] lim,
                                                     int unsigned bits);
      longint unsigned full_scale;
      longint unsigned quot;
      longint unsigned offs;
      full_scale = (64'd1 << bits) - 64'd1;
      quot       = (64'(raw) * 64'(lim) * 64'd64) / full_scale;
      offs       = 64'(lim) * 64'd32;
      return SCALED_W'(quot - offs);
   endfunction

   // Works out the result word for one accepted word and advances the state.
   function automatic rsp_payload_type decode_frame(req_payload_type w);
      rsp_payload_type       o;
      logic [7:0]            b [8];
      logic [15:0]           ack_id;
      logic [CSR_DATA_W-1:0] e;
      int                    m;
      o = '0;                                  // RK_IGNORED, all fields zero
      for (int i = 0; i < 8; i++)
         b[i] = w.frame_data[8*i +: 8];
      ack_id = {b[1], b[0]};
      if (w.command == CMD_CLR_ACK) begin
         ack_valid     = 1'b0;
         ack_word      = '0;
         o.result_kind = RK_CLEAR;
      end else if (w.command == CMD_CLR_SEEN) begin
         seen_ids      = '0;
         o.result_kind = RK_CLEAR;
      end else if (w.command == CMD_FRAME && w.is_standard && w.length >= 4'd8) begin
         if ((b[2] == OP_READ || b[2] == OP_WRITE) && ack_id != 16'd0 &&
             ack_id <= ID_SPAN && !ack_valid) begin
            // id 32 is a legal ack but has no bit in the mask
            if (ack_id < ID_SPAN)
               seen_ids[ack_id[4:0]] = 1'b1;
            ack_valid     = 1'b1;
            ack_word      = {ack_id, b[2], b[3], w.frame_data[63:32]};
            o.result_kind = RK_ACK;
         end else if (w.std_id != BROADCAST_ID) begin
            if (w.std_id < ID_SPAN)
               seen_ids[w.std_id[4:0]] = 1'b1;
            seen_ids[b[0][3:0]] = 1'b1;
            m = find_motor(w.std_id, b[0][3:0]);
            if (m >= 0) begin
               e                    = tbl_entry[m];
               fb_counts[m]         = fb_counts[m] + 1'b1;
               o.result_kind        = RK_FEEDBACK;
               o.motor_index        = m[1:0];
               o.error_flags        = b[0][7:4];
               o.motor_low_id       = b[0][3:0];
               o.position           = scale_raw({b[1], b[2]},
                                                e[ENT_POS_LSB +: LIMIT_W], POS_BITS);
               o.velocity           = scale_raw({4'b0, b[3], b[4][7:4]},
                                                e[ENT_VEL_LSB +: LIMIT_W], VT_BITS);
               o.torque             = scale_raw({4'b0, b[4][3:0], b[5]},
                                                e[ENT_TOR_LSB +: LIMIT_W], VT_BITS);
               o.driver_temperature = b[6];
               o.rotor_temperature  = b[7];
               o.frame_count        = fb_counts[m];
            end
         end
      end
      o.seen_mask  = seen_ids;
      o.ack_record = ack_word;
      return o;
   endfunction

   // ------------------------------------------------------------------------
   // Word builders
   // ------------------------------------------------------------------------
   function automatic req_payload_type make_frame(logic [1:0] cmd, logic [ID_W-1:0] id,
                                                  logic is_std, logic [3:0] len,
                                                  logic [DATA_W-1:0] data);
      req_payload_type w;
      w.command     = cmd;
      w.std_id      = id;
      w.is_standard = is_std;
      w.length      = len;
      w.frame_data  = data;
      return w;
   endfunction

   // byte 0 nibbles, 16-bit position, 12-bit velocity and torque, two temps
   function automatic logic [DATA_W-1:0] pack_feedback(logic [3:0] low, logic [3:0] err,
                                                       logic [15:0] praw, logic [11:0] vraw,
                                                       logic [11:0] traw, logic [7:0] t_drv,
                                                       logic [7:0] t_rot);
      return {t_rot, t_drv, traw[7:0], vraw[3:0], traw[11:8], vraw[11:4],
              praw[7:0], praw[15:8], err, low};
   endfunction

   function automatic logic [DATA_W-1:0] pack_ack(logic [15:0] aid, logic [7:0] op,
                                                  logic [7:0] reg_sel, logic [31:0] value);
      return {value, reg_sel, op, aid};
   endfunction

   function automatic logic [CSR_DATA_W-1:0] make_entry(logic [ID_W-1:0] id,
                                                        logic [LIMIT_W-1:0] plim,
                                                        logic [LIMIT_W-1:0] vlim,
                                                        logic [LIMIT_W-1:0] tlim);
      return {tlim, vlim, plim, id};
   endfunction

   // near_ids keeps can ids in 0..40, around the range the seen mask covers
   function automatic logic [CSR_DATA_W-1:0] random_entry(bit near_ids);
      logic [ID_W-1:0]    id;
      logic [LIMIT_W-1:0] lim [3];
      id = near_ids ? ID_W'($urandom_range(40, 0)) : ID_W'($urandom);
      for (int i = 0; i < 3; i++) begin
         case ($urandom_range(7, 0))
            0:       lim[i] = '0;
            1:       lim[i] = '1;
            default: lim[i] = LIMIT_W'($urandom);
         endcase
      end
      return make_entry(id, lim[0], lim[1], lim[2]);
   endfunction

   // Mostly well-formed feedback and ack frames aimed at the current table,
   // plus clears, broadcasts, malformed frames and plain noise.
   function automatic req_payload_type random_word();
      req_payload_type   w;
      int unsigned       pick;
      int unsigned       n;
      int unsigned       k;
      logic [15:0]       aid;
      logic [7:0]        op;
      n    = active_motors();
      k    = (n == 0) ? 0 : $urandom_range(n - 1, 0);
      pick = $urandom_range(99, 0);
      w    = make_frame(CMD_FRAME, ID_W'($urandom_range(47, 0)), 1'b1, 4'd8,
                        {$urandom, $urandom});
      if (pick < 18) begin
         w.std_id = tbl_entry[k][ID_W-1:0];
      end else if (pick < 30) begin
         w.std_id = tbl_entry[k][ID_W-1:0] + ID_W'(FEEDBACK_OFFSET);
      end else if (pick < 42) begin
         // nibble fallback
         w.std_id          = ID_W'($urandom);
         w.frame_data[3:0] = tbl_entry[k][3:0];
      end else if (pick < 48) begin
         w.std_id = ID_W'($urandom);
      end else if (pick < 60) begin
         aid = ($urandom_range(9, 0) == 0) ? 16'($urandom_range(40, 0))
                                           : 16'($urandom_range(32, 1));
         op  = $urandom_range(1, 0) ? OP_READ : OP_WRITE;
         w.frame_data[23:0] = {op, aid};
         if ($urandom_range(3, 0) == 0)
            w.std_id = BROADCAST_ID;
      end else if (pick < 68) begin
         w.command = CMD_CLR_ACK;
      end else if (pick < 72) begin
         w.command = CMD_CLR_SEEN;
      end else if (pick < 74) begin
         w.command = CMD_UNUSED;
      end else if (pick < 80) begin
         w.std_id = BROADCAST_ID;
      end else if (pick < 86) begin
         w.length = 4'($urandom_range(15, 9));
      end else if (pick < 93) begin
         // extended or short frame
         w.is_standard = 1'($urandom);
         w.length      = w.is_standard ? 4'($urandom_range(7, 0)) : 4'($urandom);
      end else begin
         w = make_frame(2'($urandom), ID_W'($urandom), 1'($urandom), 4'($urandom),
                        {$urandom, $urandom});
      end
      return w;
   endfunction

   // ------------------------------------------------------------------------
   // Sender side: inputs change on the falling edge only
   // ------------------------------------------------------------------------
   // Returns at the rising edge that takes the word; valid stays up so the
   // next word can follow back to back.
   task automatic send_word(input req_payload_type w);
      int unsigned gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid   = 1'b1;
      req_bus.payload = w;
      do
         @(posedge clock);
      while (!req_bus.ready);
      frame_outcomes.push_back(decode_frame(w));
   endtask

   // sender idle until every result is back, then wait out the pipeline
   task automatic wait_outcomes_drained();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (frame_outcomes.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // only called with the block idle
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      req_bus.valid = 1'b0;
      csr_we        = 1'b1;
      csr_index     = idx;
      csr_wdata     = value;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == CSR_MOTOR_COUNT)
         tbl_count = value[COUNT_W-1:0];
      else if (int'(idx) - int'(CSR_MOTOR_ENTRY0) < N_MOTORS)
         tbl_entry[int'(idx) - int'(CSR_MOTOR_ENTRY0)] = value;
   endtask

   task automatic program_table(input logic [COUNT_W-1:0] count,
                                input logic [CSR_DATA_W-1:0] e0,
                                input logic [CSR_DATA_W-1:0] e1,
                                input logic [CSR_DATA_W-1:0] e2,
                                input logic [CSR_DATA_W-1:0] e3);
      write_csr(CSR_MOTOR_COUNT, CSR_DATA_W'(count));
      write_csr(CSR_INDEX_W'(int'(CSR_MOTOR_ENTRY0) + 0), e0);
      write_csr(CSR_INDEX_W'(int'(CSR_MOTOR_ENTRY0) + 1), e1);
      write_csr(CSR_INDEX_W'(int'(CSR_MOTOR_ENTRY0) + 2), e2);
      write_csr(CSR_INDEX_W'(int'(CSR_MOTOR_ENTRY0) + 3), e3);
   endtask

   // ------------------------------------------------------------------------
   // Receiver side: ready with random stalls, plus the long hold-off
   // ------------------------------------------------------------------------
   initial begin : rsp_ready_driver
      int unsigned stall_left;
      stall_left    = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_bus.ready   = 1'b0;
            rsp_hold_cycles = rsp_hold_cycles - 1;
         end else if (stall_left > 0) begin
            rsp_bus.ready = 1'b0;
            stall_left    = stall_left - 1;
         end else begin
            rsp_bus.ready = 1'b1;
            stall_left    = pick_gap();
         end
      end
   end

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
   endfunction

   // every result word taken is held against the oldest prediction
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (frame_outcomes.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("%0t: result word with nothing expected: %h", $time,
                        rsp_bus.payload);
         end else begin
            want = frame_outcomes.pop_front();
            check_field("result_kind", want.result_kind, rsp_bus.payload.result_kind);
            check_field("motor_index", want.motor_index, rsp_bus.payload.motor_index);
            check_field("error_flags", want.error_flags, rsp_bus.payload.error_flags);
            check_field("motor_low_id", want.motor_low_id, rsp_bus.payload.motor_low_id);
            check_field("position", want.position, rsp_bus.payload.position);
            check_field("velocity", want.velocity, rsp_bus.payload.velocity);
            check_field("torque", want.torque, rsp_bus.payload.torque);
            check_field("driver_temperature", want.driver_temperature,
                        rsp_bus.payload.driver_temperature);
            check_field("rotor_temperature", want.rotor_temperature,
                        rsp_bus.payload.rotor_temperature);
            check_field("frame_count", want.frame_count, rsp_bus.payload.frame_count);
            check_field("seen_mask", want.seen_mask, rsp_bus.payload.seen_mask);
            check_field("ack_record", want.ack_record, rsp_bus.payload.ack_record);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // Table still empty after reset: feedback only marks the seen mask.
   task automatic test_empty_table();
      send_word(make_frame(CMD_FRAME, 11'd5, 1'b1, 4'd8,
                           pack_feedback(4'h9, 4'h3, 16'h1234, 12'h456, 12'h789,
                                         8'd40, 8'd50)));
      send_word(make_frame(CMD_UNUSED, 11'd5, 1'b1, 4'd8, '1));
      wait_outcomes_drained();
   endtask

   // Count above the table size, limit extremes, each lookup path, ack rules.
   task automatic test_table_extremes();
      program_table(3'd7,
                    make_entry(11'h001, 16'hFFFF, 16'hFFFF, 16'hFFFF),
                    make_entry(11'h7F0, 16'h0000, 16'h0000, 16'h0000),
                    make_entry(11'h02A, 16'h0C90, 16'h0100, 16'h0780),
                    make_entry(11'h7EF, 16'h8000, 16'h0001, 16'h7FFF));
      // raw all zeros / all ones: bottom and top of the scale
      send_word(make_frame(CMD_FRAME, 11'h001, 1'b1, 4'd8, '0));
      send_word(make_frame(CMD_FRAME, 11'h011, 1'b1, 4'd8, '1));
      // zero limits scale everything to zero
      send_word(make_frame(CMD_FRAME, 11'h7F0, 1'b1, 4'd8,
                           pack_feedback(4'h0, 4'hF, 16'hFFFF, 12'hFFF, 12'h000,
                                         8'hFF, 8'h00)));
      // nibble fallback, then no match at all
      send_word(make_frame(CMD_FRAME, 11'h300, 1'b1, 4'd8,
                           pack_feedback(4'hA, 4'h5, 16'h7FFF, 12'h800, 12'h7FF,
                                         8'd25, 8'd30)));
      send_word(make_frame(CMD_FRAME, 11'h400, 1'b1, 4'd8,
                           pack_feedback(4'h5, 4'h0, 16'h8000, 12'h001, 12'hFFE,
                                         8'd1, 8'd2)));
      // broadcast id dropped
      send_word(make_frame(CMD_FRAME, BROADCAST_ID, 1'b1, 4'd8,
                           pack_feedback(4'h1, 4'h0, 16'h8000, 12'h123, 12'h321,
                                         8'd3, 8'd4)));
      // ack captured even on the broadcast id
      send_word(make_frame(CMD_FRAME, BROADCAST_ID, 1'b1, 4'd8,
                           pack_ack(16'd1, OP_READ, 8'h12, 32'hDEADBEEF)));
      // ack already held: falls through to the drop, then to feedback
      send_word(make_frame(CMD_FRAME, BROADCAST_ID, 1'b1, 4'd8,
                           pack_ack(16'd7, OP_WRITE, 8'h34, 32'h01234567)));
      send_word(make_frame(CMD_FRAME, 11'h001, 1'b1, 4'd8,
                           pack_ack(16'd15, OP_WRITE, 8'h56, 32'h89ABCDEF)));
      send_word(make_frame(CMD_CLR_ACK, '0, 1'b0, 4'd0, '0));
      // ack id 32 is taken but sets no mask bit
      send_word(make_frame(CMD_FRAME, 11'h05F, 1'b1, 4'd8,
                           pack_ack(16'd32, OP_WRITE, 8'hFF, 32'hFFFFFFFF)));
      send_word(make_frame(CMD_CLR_ACK, '1, 1'b1, 4'd15, '1));
      // ack ids 0, 33 and one with a nonzero high byte are plain feedback
      send_word(make_frame(CMD_FRAME, 11'h02A, 1'b1, 4'd8,
                           pack_ack(16'd0, OP_READ, 8'h01, 32'h00000001)));
      send_word(make_frame(CMD_FRAME, 11'h123, 1'b1, 4'd8,
                           pack_ack(16'd33, OP_READ, 8'h02, 32'h80000000)));
      send_word(make_frame(CMD_FRAME, 11'h7EF, 1'b1, 4'd8,
                           pack_ack(16'h0101, OP_READ, 8'h03, 32'h7FFFFFFF)));
      send_word(make_frame(CMD_CLR_SEEN, '0, 1'b0, 4'd0, '0));
      // extended and short frames are ignored; a long length code is not
      send_word(make_frame(CMD_FRAME, 11'h001, 1'b0, 4'd8, {$urandom, $urandom}));
      send_word(make_frame(CMD_FRAME, 11'h001, 1'b1, 4'd7, {$urandom, $urandom}));
      send_word(make_frame(CMD_FRAME, 11'h001, 1'b1, 4'd15, {$urandom, $urandom}));
      send_word(make_frame(CMD_FRAME, 11'h000, 1'b0, 4'd0, '0));
      wait_outcomes_drained();
   endtask

   // Random traffic under four tables; the last one starts with no idling.
   task automatic test_random_phases();
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: program_table(3'd4, random_entry(1'b1), random_entry(1'b1),
                             random_entry(1'b1), random_entry(1'b1));
            1: program_table(3'd1, make_entry(ID_W'($urandom_range(31, 0)), '1, '1, '1),
                             random_entry(1'b1), random_entry(1'b1), random_entry(1'b1));
            2: program_table(3'd6, random_entry(1'b0), random_entry(1'b0),
                             random_entry(1'b0), random_entry(1'b0));
            default: program_table(3'd3, random_entry(1'b1), random_entry(1'b1),
                                   random_entry(1'b1), random_entry(1'b0));
         endcase
         gaps_on = (phase != 3);
         for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            if (i == RANDOM_PER_PHASE / 2)
               gaps_on = 1'b1;
            send_word(random_word());
         end
         wait_outcomes_drained();
      end
   endtask

   // Receiver holds off while the sender keeps offering; then the sender
   // waits for every result before it starts again.
   task automatic test_output_backpressure();
      program_table(3'd4, random_entry(1'b1), random_entry(1'b1),
                    random_entry(1'b1), random_entry(1'b1));
      gaps_on         = 1'b0;
      rsp_hold_cycles = HOLD_OFF_CYCLES;
      repeat (BURST_WORDS) send_word(random_word());
      wait_outcomes_drained();
      gaps_on = 1'b1;
      repeat (BURST_WORDS) send_word(random_word());
      wait_outcomes_drained();
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      clock           = 1'b0;
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      req_bus.valid   = 1'b0;
      req_bus.payload = '0;
      gaps_on         = 1'b1;
      rsp_hold_cycles = 0;
      error_count     = 0;
      // predictor starts from the reset state
      tbl_count = '0;
      seen_ids  = '0;
      ack_valid = 1'b0;
      ack_word  = '0;
      for (int i = 0; i < N_MOTORS; i++) begin
         tbl_entry[i] = '0;
         fb_counts[i] = '0;
      end
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_table();
      test_table_extremes();
      test_random_phases();
      test_output_backpressure();
      wait_outcomes_drained();

      if (error_count == 0 && frame_outcomes.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #(10_000_000);
      $display("TEST FAILED");
      $finish;
   end

endmodule

### filelist.f
rtl/mcfr_pkg.sv
rtl/mcfr_if.sv
rtl/motor_can_feedback_receiver_core.sv
verif/motor_can_feedback_receiver_core_tb.sv
